FILE: src/asv_pkg.sv
package asv_pkg;

   // default sizes
   localparam int NUM_ANTENNAS_DEF = 8;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int WEIGHT_BITS_DEF  = 16;

   // spacing register, unsigned Q2.8
   localparam int SCALE_W               = 10;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd256;

   // cordic datapath
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 33;
   localparam int ZW           = 32;
   localparam logic [30:0] PI_Q29 = 31'd1686629713;
   localparam logic signed [CORDIC_W-1:0] CORDIC_K = 33'sd652032874;

   // element position coordinates and dot product
   localparam int POS_W = 5;
   localparam int DOT_W = 38;
   localparam int PH_W  = 48;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // arctangent of 2^-i in Q30 radians
   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] a;
      case (i)
         0:  a = 32'sd843314856;
         1:  a = 32'sd497837829;
         2:  a = 32'sd263043837;
         3:  a = 32'sd133525158;
         4:  a = 32'sd67021686;
         5:  a = 32'sd33543515;
         6:  a = 32'sd16775850;
         7:  a = 32'sd8388437;
         8:  a = 32'sd4194282;
         9:  a = 32'sd2097149;
         10: a = 32'sd1048575;
         11: a = 32'sd524287;
         12: a = 32'sd262143;
         13: a = 32'sd131071;
         14: a = 32'sd65535;
         15: a = 32'sd32767;
         16: a = 32'sd16383;
         17: a = 32'sd8191;
         18: a = 32'sd4095;
         19: a = 32'sd2047;
         20: a = 32'sd1023;
         21: a = 32'sd511;
         22: a = 32'sd255;
         23: a = 32'sd127;
         24: a = 32'sd63;
         25: a = 32'sd31;
         26: a = 32'sd15;
         27: a = 32'sd7;
         28: a = 32'sd3;
         29: a = 32'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

   // element positions in units of the element spacing
   function automatic logic signed [POS_W-1:0] pos_coord(input logic [2:0] idx,
                                                        input logic [1:0] axis);
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      case (idx)
         3'd0: begin py = -5'sd9; pz =  5'sd9; end
         3'd1: begin py = -5'sd1; pz =  5'sd9; end
         3'd2: begin py =  5'sd9; pz =  5'sd9; end
         3'd3: begin py = -5'sd5; pz =  5'sd1; end
         3'd4: begin py =  5'sd5; pz = -5'sd1; end
         3'd5: begin py = -5'sd9; pz = -5'sd9; end
         3'd6: begin py =  5'sd1; pz = -5'sd9; end
         default: begin py = 5'sd9; pz = -5'sd9; end
      endcase
      case (axis)
         AXIS_Y:  return py;
         AXIS_Z:  return pz;
         default: return '0;
      endcase
   endfunction

endpackage

FILE: src/asv_if.sv
interface asv_req_if #(
   parameter int ANGLE_BITS = asv_pkg::ANGLE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] azimuth_angle;
   logic signed [ANGLE_BITS-1:0] elevation_angle;

   modport source (output valid, azimuth_angle, elevation_angle, input ready);
   modport sink   (input valid, azimuth_angle, elevation_angle, output ready);
endinterface

interface asv_rsp_if #(
   parameter int WEIGHT_BITS = asv_pkg::WEIGHT_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    antenna_index;
   logic signed [WEIGHT_BITS-1:0] weight_real;
   logic signed [WEIGHT_BITS-1:0] weight_imag;
   logic                          last_element;

   modport source (output valid, antenna_index, weight_real, weight_imag, last_element,
                   input ready);
   modport sink   (input valid, antenna_index, weight_real, weight_imag, last_element,
                   output ready);
endinterface

interface asv_csr_if;
   logic                           valid;
   logic                           ready;
   logic [asv_pkg::SCALE_W-1:0]    spacing_scale;

   modport source (output valid, spacing_scale, input ready);
   modport sink   (input valid, spacing_scale, output ready);
endinterface

FILE: src/asv_cordic.sv
module asv_cordic #(
   parameter int TAG_W = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [31:0]                           in_turn,
   input  logic [TAG_W-1:0]                      in_tag,
   output logic                                  out_valid,
   output logic signed [asv_pkg::CORDIC_W-1:0]   out_cos,
   output logic signed [asv_pkg::CORDIC_W-1:0]   out_sin,
   output logic [TAG_W-1:0]                      out_tag
);
   import asv_pkg::*;

   localparam int N = CORDIC_STEPS;

   logic [N:0]                   v_ff;
   logic [1:0]                   q_ff [N+1];
   logic [TAG_W-1:0]             t_ff [N+1];
   logic signed [CORDIC_W-1:0]   x_ff [N+1];
   logic signed [CORDIC_W-1:0]   y_ff [N+1];
   logic signed [ZW-1:0]         z_ff [N+1];
   logic [60:0]                  zprod;

   logic                         ov_ff;
   logic signed [CORDIC_W-1:0]   oc_ff;
   logic signed [CORDIC_W-1:0]   os_ff;
   logic [TAG_W-1:0]             ot_ff;

   // residue within the quadrant scaled to Q30 radians
   assign zprod = 61'(in_turn[29:0]) * 61'(PI_Q29);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff[0] <= in_turn[31:30];
         t_ff[0] <= in_tag;
         z_ff[0] <= signed'({1'b0, zprod[60:30]});
         x_ff[0] <= CORDIC_K;
         y_ff[0] <= '0;
      end
   end

   // one rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      logic                       neg;

      assign dx  = y_ff[i] >>> i;
      assign dy  = x_ff[i] >>> i;
      assign neg = z_ff[i][ZW-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i+1] <= q_ff[i];
            t_ff[i+1] <= t_ff[i];
            if (neg) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end
         end
      end
   end

   // quadrant fold
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ot_ff <= t_ff[N];
         case (q_ff[N])
            2'd0: begin oc_ff <= x_ff[N];  os_ff <= y_ff[N];  end
            2'd1: begin oc_ff <= -y_ff[N]; os_ff <= x_ff[N];  end
            2'd2: begin oc_ff <= -x_ff[N]; os_ff <= -y_ff[N]; end
            default: begin oc_ff <= y_ff[N]; os_ff <= -x_ff[N]; end
         endcase
      end
   end

   assign out_valid = ov_ff;
   assign out_cos   = oc_ff;
   assign out_sin   = os_ff;
   assign out_tag   = ot_ff;

   initial_check_unused: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> ($past(en) ? $past(v_ff[N]) : 1'b1))
      else $error("cordic output valid without a valid last step");

endmodule

FILE: src/array_steering_vector.sv
// throughput: one weight beat per cycle unless stalled; NUM_ANTENNAS beats per direction
// the per-element phase cordic sets the rate: one element phase per cycle unless stalled
// a stalled result holds the sequencer and later stages; the direction cordics run on
// until the unit vector register is full; a new direction is taken while results drain
// reset is synchronous, active high; clears all valid bits and sets spacing_scale to 256
module array_steering_vector #(
   parameter int NUM_ANTENNAS = asv_pkg::NUM_ANTENNAS_DEF,
   parameter int ANGLE_BITS   = asv_pkg::ANGLE_BITS_DEF,
   parameter int WEIGHT_BITS  = asv_pkg::WEIGHT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   asv_req_if.sink     req_chan,
   asv_rsp_if.source   rsp_chan,
   asv_csr_if.sink     csr_chan
);
   import asv_pkg::*;

   localparam int KW     = (NUM_ANTENNAS > 1) ? $clog2(NUM_ANTENNAS) : 1;
   localparam int KX     = (KW > 3) ? KW : 3;
   localparam int WSHIFT = 32 - WEIGHT_BITS;
   localparam int RW     = CORDIC_W + 1;
   localparam logic [KW-1:0] K_LAST = KW'(NUM_ANTENNAS - 1);
   localparam logic signed [RW-1:0] W_LIM  = RW'(64'sd1 <<< (WEIGHT_BITS - 2));
   localparam logic signed [RW-1:0] W_HALF = RW'(64'sd1 <<< (WSHIFT - 1));

   logic [SCALE_W-1:0] scale_ff;
   logic               adv;
   logic               front_adv;
   logic               load;

   // configuration register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_chan.valid) begin
         scale_ff <= csr_chan.spacing_scale;
      end
   end

   // direction sine and cosine
   logic [31:0]                az_turn;
   logic [31:0]                el_turn;
   logic                       ang_valid;
   logic signed [CORDIC_W-1:0] ca;
   logic signed [CORDIC_W-1:0] sa;
   logic signed [CORDIC_W-1:0] ce;
   logic signed [CORDIC_W-1:0] se;
   logic                       el_valid;

   assign az_turn = {req_chan.azimuth_angle, {(32 - ANGLE_BITS){1'b0}}};
   assign el_turn = {req_chan.elevation_angle, {(32 - ANGLE_BITS){1'b0}}};
   assign req_chan.ready = front_adv;

   asv_cordic #(.TAG_W(1)) u_az_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (front_adv),
      .in_valid  (req_chan.valid),
      .in_turn   (az_turn),
      .in_tag    (1'b0),
      .out_valid (ang_valid),
      .out_cos   (ca),
      .out_sin   (sa),
      .out_tag   ()
   );

   asv_cordic #(.TAG_W(1)) u_el_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (front_adv),
      .in_valid  (req_chan.valid),
      .in_turn   (el_turn),
      .in_tag    (1'b0),
      .out_valid (el_valid),
      .out_cos   (ce),
      .out_sin   (se),
      .out_tag   ()
   );

   // unit vector
   logic signed [2*CORDIC_W-1:0] ux_prod;
   logic signed [2*CORDIC_W-1:0] uy_prod;
   logic                         uv_valid_ff;
   logic signed [CORDIC_W-1:0]   u0_ff;
   logic signed [CORDIC_W-1:0]   u1_ff;
   logic signed [CORDIC_W-1:0]   u2_ff;

   assign ux_prod = ca * se;
   assign uy_prod = sa * se;

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_valid_ff <= 1'b0;
      end else if (front_adv) begin
         uv_valid_ff <= ang_valid & el_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         u0_ff <= ux_prod[CORDIC_W+29:30];
         u1_ff <= uy_prod[CORDIC_W+29:30];
         u2_ff <= ce;
      end
   end

   // element sequencer
   logic                       busy_ff;
   logic [KW-1:0]              k_ff;
   logic signed [CORDIC_W-1:0] hx_ff;
   logic signed [CORDIC_W-1:0] hy_ff;
   logic signed [CORDIC_W-1:0] hz_ff;
   logic [KX-1:0]              k_ext;
   logic [2:0]                 idx;
   logic signed [DOT_W-1:0]    dot;

   assign adv       = !rsp_chan.valid || rsp_chan.ready;
   assign load      = uv_valid_ff && (!busy_ff || (adv && k_ff == K_LAST));
   assign front_adv = !uv_valid_ff || load;
   assign k_ext     = KX'(k_ff);
   assign idx       = k_ext[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         k_ff    <= '0;
      end else if (adv && busy_ff) begin
         if (k_ff == K_LAST) begin
            busy_ff <= 1'b0;
         end
         k_ff <= k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hx_ff <= u0_ff;
         hy_ff <= u1_ff;
         hz_ff <= u2_ff;
      end
   end

   assign dot = DOT_W'(pos_coord(idx, AXIS_X)) * DOT_W'(hx_ff)
              + DOT_W'(pos_coord(idx, AXIS_Y)) * DOT_W'(hy_ff)
              + DOT_W'(pos_coord(idx, AXIS_Z)) * DOT_W'(hz_ff);

   // element dot product stage
   logic                    e_valid_ff;
   logic signed [DOT_W-1:0] e_dot_ff;
   logic [3:0]              e_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_dot_ff <= dot;
         e_tag_ff <= {idx, k_ff == K_LAST};
      end
   end

   // phase as a turn, scaled by spacing
   logic signed [PH_W-1:0] ph_sum;
   logic                   p_valid_ff;
   logic [31:0]            p_turn_ff;
   logic [3:0]             p_tag_ff;

   assign ph_sum = PH_W'($signed({1'b0, scale_ff})) * PH_W'(e_dot_ff) + 48'sd64;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_turn_ff <= ph_sum[38:7];
         p_tag_ff  <= e_tag_ff;
      end
   end

   // element phase sine and cosine
   logic                       w_valid;
   logic signed [CORDIC_W-1:0] wc;
   logic signed [CORDIC_W-1:0] ws;
   logic [3:0]                 w_tag;

   asv_cordic #(.TAG_W(4)) u_ph_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p_valid_ff),
      .in_turn   (p_turn_ff),
      .in_tag    (p_tag_ff),
      .out_valid (w_valid),
      .out_cos   (wc),
      .out_sin   (ws),
      .out_tag   (w_tag)
   );

   // round half up and clamp into the output register
   logic signed [RW-1:0] rc;
   logic signed [RW-1:0] rs;
   logic signed [RW-1:0] rc_sat;
   logic signed [RW-1:0] rs_sat;

   assign rc = (RW'(wc) + W_HALF) >>> WSHIFT;
   assign rs = (RW'(ws) + W_HALF) >>> WSHIFT;

   always_comb begin
      rc_sat = rc;
      if (rc > W_LIM) rc_sat = W_LIM;
      if (rc < -W_LIM) rc_sat = -W_LIM;
      rs_sat = rs;
      if (rs > W_LIM) rs_sat = W_LIM;
      if (rs < -W_LIM) rs_sat = -W_LIM;
   end

   logic                          o_valid_ff;
   logic [2:0]                    o_idx_ff;
   logic signed [WEIGHT_BITS-1:0] o_re_ff;
   logic signed [WEIGHT_BITS-1:0] o_im_ff;
   logic                          o_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= w_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_idx_ff  <= w_tag[3:1];
         o_last_ff <= w_tag[0];
         o_re_ff   <= rc_sat[WEIGHT_BITS-1:0];
         o_im_ff   <= rs_sat[WEIGHT_BITS-1:0];
      end
   end

   assign rsp_chan.valid         = o_valid_ff;
   assign rsp_chan.antenna_index = o_idx_ff;
   assign rsp_chan.weight_real   = o_re_ff;
   assign rsp_chan.weight_imag   = o_im_ff;
   assign rsp_chan.last_element  = o_last_ff;

   // checks
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> k_ff <= K_LAST)
      else $error("element counter past last antenna");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && o_last_ff) |-> o_idx_ff == 3'(NUM_ANTENNAS - 1))
      else $error("last flag on wrong antenna");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !adv) |=> !(busy_ff && k_ff == '0 && $past(k_ff) != '0))
      else $error("sequencer reloaded while stalled");

   a_front_ready: assert property (@(posedge clock) disable iff (reset)
      (uv_valid_ff && !load) |=> uv_valid_ff && $stable(u0_ff))
      else $error("unit vector lost while sequencer busy");

endmodule
